@@ sv/csch_pkg.sv @@
// Shared constants, types and the cell level map for the confusion histogram.
// No dependencies; used by every module of the block.
package csch_pkg;

    localparam int LEVELS      = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int DEPTH       = LEVELS * LEVELS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEVEL_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 32;
    localparam int IN_W        = 72;
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [ADDR_W-1:0]      addr_t;

    // One access to the count store: update (write=1) or lookup.
    typedef struct packed {
        logic  valid;
        logic  write;
        addr_t addr;
    } op_t;

    // Inverse Gray map from 4-bit cell pattern to level.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [3:0] pattern);
        logic [LEVEL_W-1:0] lvl;
        case (pattern)
            4'd0:    lvl = 4'd6;
            4'd1:    lvl = 4'd5;
            4'd2:    lvl = 4'd7;
            4'd3:    lvl = 4'd14;
            4'd4:    lvl = 4'd9;
            4'd5:    lvl = 4'd12;
            4'd6:    lvl = 4'd8;
            4'd7:    lvl = 4'd13;
            4'd8:    lvl = 4'd3;
            4'd9:    lvl = 4'd4;
            4'd10:   lvl = 4'd2;
            4'd11:   lvl = 4'd15;
            4'd12:   lvl = 4'd10;
            4'd13:   lvl = 4'd11;
            4'd14:   lvl = 4'd1;
            default: lvl = 4'd0;
        endcase
        return lvl;
    endfunction

    function automatic logic in_range(input logic [LEVEL_W-1:0] lvl);
        return {1'b0, lvl} < (LEVEL_W + 1)'(LEVELS);
    endfunction

    function automatic addr_t pair_addr(input logic [LEVEL_W-1:0] rd,
                                        input logic [LEVEL_W-1:0] wr);
        return ADDR_W'(32'(rd) * LEVELS + 32'(wr));
    endfunction

endpackage

@@ sv/csch_seq.sv @@
// Bit-position sequencer: walks the eight cell positions MSB first and issues
// one count-store update per cycle. Depends on csch_pkg.
module csch_seq (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start_i,
    input  logic [4*csch_pkg::BYTE_W-1:0]        written_i, // lower, middle, upper, top
    input  logic [4*csch_pkg::BYTE_W-1:0]        read_i,    // lower, middle, upper, top
    output csch_pkg::op_t                        op_o,
    output logic                                 done_o
);

    logic [csch_pkg::BYTE_W-1:0] wr_byte_reg [4];
    logic [csch_pkg::BYTE_W-1:0] rd_byte_reg [4];
    logic [2:0]                  pos_cnt_reg;
    logic                        active_reg;
    logic [3:0]                  wr_pat;
    logic [3:0]                  rd_pat;
    logic [csch_pkg::LEVEL_W-1:0] wr_lvl;
    logic [csch_pkg::LEVEL_W-1:0] rd_lvl;

    // Current cell pattern = MSBs of the four page bytes, top page highest.
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            wr_pat[p] = wr_byte_reg[p][csch_pkg::BYTE_W-1];
            rd_pat[p] = rd_byte_reg[p][csch_pkg::BYTE_W-1];
        end
        wr_lvl = csch_pkg::level_of(wr_pat);
        rd_lvl = csch_pkg::level_of(rd_pat);
    end

    assign op_o.valid = active_reg && csch_pkg::in_range(rd_lvl)
                        && csch_pkg::in_range(wr_lvl);
    assign op_o.write = 1'b1;
    assign op_o.addr  = csch_pkg::pair_addr(rd_lvl, wr_lvl);
    assign done_o     = active_reg && (pos_cnt_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            pos_cnt_reg <= 3'd0;
        end else if (start_i) begin
            active_reg  <= 1'b1;
            pos_cnt_reg <= 3'd0;
        end else if (active_reg) begin
            active_reg  <= (pos_cnt_reg != 3'd7);
            pos_cnt_reg <= pos_cnt_reg + 3'd1;
        end
    end

    // Page bytes shift left so the next position is always at the MSB.
    always_ff @(posedge aclk) begin
        for (int p = 0; p < 4; p++) begin
            if (start_i) begin
                wr_byte_reg[p] <= written_i[p*csch_pkg::BYTE_W +: csch_pkg::BYTE_W];
                rd_byte_reg[p] <= read_i[p*csch_pkg::BYTE_W +: csch_pkg::BYTE_W];
            end else if (active_reg) begin
                wr_byte_reg[p] <= {wr_byte_reg[p][csch_pkg::BYTE_W-2:0], 1'b0};
                rd_byte_reg[p] <= {rd_byte_reg[p][csch_pkg::BYTE_W-2:0], 1'b0};
            end
        end
    end

endmodule

@@ sv/csch_store.sv @@
// Count store: pair-count memory with per-entry valid bits and the shared
// saturating increment unit (read, then write back). Depends on csch_pkg.
module csch_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csch_pkg::op_t        op_i,
    input  logic                 clr_i,
    output csch_pkg::count_t     value_o
);

    csch_pkg::count_t             mem [csch_pkg::DEPTH];
    logic [csch_pkg::DEPTH-1:0]   vbit_reg;
    logic                         s1_valid_reg;
    logic                         s1_write_reg;
    csch_pkg::addr_t              s1_addr_reg;
    csch_pkg::count_t             rdata_reg;
    logic                         rvbit_reg;
    logic                         hazard_reg;
    csch_pkg::count_t             wr_data_reg;
    csch_pkg::count_t             old_val;
    csch_pkg::count_t             new_val;
    logic                         wr_en;

    assign wr_en = s1_valid_reg && s1_write_reg;

    // Back-to-back hits on one entry take the value written last cycle.
    always_comb begin
        if (hazard_reg) begin
            old_val = wr_data_reg;
        end else if (rvbit_reg) begin
            old_val = rdata_reg;
        end else begin
            old_val = '0;
        end
        new_val = (&old_val) ? old_val : old_val + 1'b1;
    end

    assign value_o = old_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            vbit_reg     <= '0;
        end else begin
            s1_valid_reg <= op_i.valid;
            if (clr_i) begin
                vbit_reg <= '0;
            end else if (wr_en) begin
                vbit_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_i.valid) begin
            s1_write_reg <= op_i.write;
            s1_addr_reg  <= op_i.addr;
            rdata_reg    <= mem[op_i.addr];
            rvbit_reg    <= vbit_reg[op_i.addr];
            hazard_reg   <= wr_en && (s1_addr_reg == op_i.addr);
        end
        if (wr_en) begin
            mem[s1_addr_reg] <= new_val;
            wr_data_reg      <= new_val;
        end
    end

endmodule

@@ sv/cell_symbol_confusion_histogram_unit.sv @@
// Cell symbol confusion histogram, top level. Uses csch_pkg, csch_seq, csch_store.
// Accumulate word: accept, 8 position updates, then the write-back drain.
// Read word: lookup issued at accept; ST_QOUT then loads the count into the output
// register, waiting while it is still full. Clear and unused: accepted in ST_IDLE.
// The 8 updates per column are serialized through the single store port.
// aresetn (sync, active low) zeroes all counts at once through valid bits.
module cell_symbol_confusion_histogram_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] lower_written, [15:8] middle_written, [23:16] upper_written,
    // [31:24] top_written, [39:32] lower_read, [47:40] middle_read,
    // [55:48] upper_read, [63:56] top_read, [67:64] query_read_level,
    // [71:68] query_written_level
    input  logic [71:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] count
    output logic [31:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_QOUT
    } state_t;

    state_t                       state_reg;
    logic                         m_tvalid_reg;
    logic [csch_pkg::OUT_W-1:0]   m_tdata_reg;
    logic                         qzero_reg;

    logic                         s_acc;
    logic                         start;
    logic                         clr;
    logic                         out_free;
    csch_pkg::op_t                seq_op;
    csch_pkg::op_t                query_op;
    csch_pkg::op_t                store_op;
    logic                         seq_done;
    csch_pkg::count_t             store_value;
    logic [csch_pkg::LEVEL_W-1:0] q_rd;
    logic [csch_pkg::LEVEL_W-1:0] q_wr;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign start    = s_acc && (s_tuser == csch_pkg::CMD_ACCUM);
    assign clr      = s_acc && (s_tuser == csch_pkg::CMD_CLEAR);
    assign out_free = !m_tvalid_reg || m_tready;

    assign q_rd = s_tdata[67:64];
    assign q_wr = s_tdata[71:68];

    // Lookup issued straight from the accepted word; value settles next cycle.
    assign query_op.valid = s_acc && (s_tuser == csch_pkg::CMD_READ);
    assign query_op.write = 1'b0;
    assign query_op.addr  = csch_pkg::pair_addr(q_rd, q_wr);

    assign store_op = (state_reg == ST_RUN) ? seq_op : query_op;

    csch_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (start),
        .written_i (s_tdata[31:0]),
        .read_i    (s_tdata[63:32]),
        .op_o      (seq_op),
        .done_o    (seq_done)
    );

    csch_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_i    (store_op),
        .clr_i   (clr),
        .value_o (store_value)
    );

    // Control FSM plus output register; output reg frees the input side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            qzero_reg    <= 1'b0;
        end else begin
            // in ST_QOUT the output load below owns m_tvalid_reg
            if (m_tvalid_reg && m_tready && (state_reg != ST_QOUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_RUN;
                    end else if (query_op.valid) begin
                        // out-of-range query answers zero
                        qzero_reg <= !(csch_pkg::in_range(q_rd)
                                       && csch_pkg::in_range(q_wr));
                        state_reg <= ST_QOUT;
                    end
                end
                ST_RUN: begin
                    if (seq_done) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_IDLE;
                end
                ST_QOUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= qzero_reg ? '0 : csch_pkg::OUT_W'(store_value);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
